### hw/rtl/optimal_segmentation_dp_assert.svh
// assertion macros shared by the checker
`ifndef OPTIMAL_SEGMENTATION_DP_ASSERT_SVH
`define OPTIMAL_SEGMENTATION_DP_ASSERT_SVH

// same-cycle implication
`define OSD_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("osd check failed");

// next-cycle implication
`define OSD_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("osd check failed");

`endif

### hw/rtl/osd_pkg.sv
package osd_pkg;

  localparam int DEF_MAX_POINTS  = 256;
  localparam int DEF_MAX_SEG_LEN = 64;
  localparam int DEF_MAX_CP      = 8;

  localparam int COST_W     = 32;
  localparam int BND_W      = 9;
  localparam int CNT_W      = 3;
  localparam int NP_W       = 9;
  localparam int ML_W       = 7;
  localparam int NR_W       = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [COST_W-1:0] COST_INF = '1;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SEG_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_CP_ROWS = 2'd2;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_RUN  = 1'b1;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } cell_ctl_t;

  // saturating add, all-ones is infinite
  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (a == COST_INF || b == COST_INF || s >= {1'b0, COST_INF}) return COST_INF;
    return s[COST_W-1:0];
  endfunction

endpackage

### hw/rtl/osd_ram.sv
module osd_ram #(
  parameter int W = 32,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/osd_cell.sv
module osd_cell import osd_pkg::*; (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [BND_W-1:0] left,
  input  logic [BND_W-1:0] right,
  output logic [BND_W-1:0] val
);
  // push moves the chain towards the tail, pop towards the head
  always_ff @(posedge clk) begin
    if (ctl.clear) val <= '0;
    else if (ctl.push) val <= left;
    else if (ctl.pop) val <= right;
  end
endmodule

### hw/rtl/optimal_segmentation_dp.sv
// load beat: no result. run beat: every row c and column j scans its window of up to
// max_seg_len+1 candidates at one per cycle, set by the single read port of the cost table,
// with S_COLINIT ahead and S_DRAIN, S_WRCOL after each column; then per row a backtrack
// through S_ROWRD, S_TOT and an S_BTRD, S_BTWAIT pair per step back, then num_cp_rows
// result beats. one run at a time; input is stalled until the last beat is loaded into the output register.
// rst (synchronous) clears control and sets num_points 256, max_seg_len 64, num_cp_rows 8.
module optimal_segmentation_dp import osd_pkg::*; #(
  parameter int MAX_POINTS  = DEF_MAX_POINTS,
  parameter int MAX_SEG_LEN = DEF_MAX_SEG_LEN,
  parameter int MAX_CP      = DEF_MAX_CP
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  mode,
  input  logic [5:0]            seg_len_index,
  input  logic [7:0]            start_point,
  input  logic [COST_W-1:0]     cost_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CNT_W-1:0]      change_count,
  output logic [CNT_W-1:0]      slot,
  output logic [BND_W-1:0]      boundary,
  output logic [COST_W-1:0]     total_cost,
  output logic                  infeasible,
  output logic                  last
);
  localparam int PW     = $clog2(MAX_POINTS);
  localparam int LW     = (MAX_SEG_LEN > 1) ? $clog2(MAX_SEG_LEN) : 1;
  localparam int CW     = $clog2(MAX_POINTS + 1);
  localparam int CPW    = (MAX_CP > 1) ? $clog2(MAX_CP) : 1;
  localparam int ML_CAP = (MAX_SEG_LEN < MAX_POINTS) ? MAX_SEG_LEN : MAX_POINTS;
  localparam int SEG_AW = LW + PW;
  localparam int TAB_AW = CPW + CW;

  typedef enum logic [3:0] {
    S_IDLE, S_COLINIT, S_SCAN, S_DRAIN, S_WRCOL,
    S_ROWRD, S_TOT, S_BTRD, S_BTWAIT, S_EMIT
  } state_t;

  state_t state;

  logic [NP_W-1:0]   num_points;
  logic [ML_W-1:0]   max_seg_len;
  logic [NR_W-1:0]   num_cp_rows;

  logic [CW-1:0]     n, ml, j, i, i_d, imin, pos;
  logic [CNT_W-1:0]  rows_m1, c, s, sl;
  logic              v1, eq_d;
  logic [COST_W-1:0] zmin, total;

  logic [CW-1:0]     n_start, ml_start;
  logic [CNT_W-1:0]  rows_start;
  logic              in_acc, out_free, seg_we;

  logic [SEG_AW-1:0] seg_waddr, seg_raddr;
  logic [COST_W-1:0] seg_rdata;
  logic [TAB_AW-1:0] best_raddr, col_waddr, bp_raddr;
  logic [COST_W-1:0] best_rdata;
  logic [CW-1:0]     bp_rdata;
  logic              col_we;

  logic [COST_W-1:0] prev_cost, seg_term, z;

  cell_ctl_t         cctl;
  logic [BND_W-1:0]  push_val;
  logic [BND_W-1:0]  chain [MAX_CP];

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    if (num_points == '0) n_start = CW'(1);
    else if (32'(num_points) > MAX_POINTS) n_start = CW'(MAX_POINTS);
    else n_start = CW'(num_points);
    if (max_seg_len == '0) ml_start = CW'(1);
    else if (32'(max_seg_len) > ML_CAP) ml_start = CW'(ML_CAP);
    else ml_start = CW'(max_seg_len);
    if (num_cp_rows == '0) rows_start = '0;
    else if (32'(num_cp_rows) > MAX_CP) rows_start = CNT_W'(MAX_CP - 1);
    else rows_start = CNT_W'(num_cp_rows - 4'd1);
  end

  // cost table, row per segment length
  assign seg_we = in_acc && (mode == MODE_LOAD) && (32'(seg_len_index) < MAX_SEG_LEN) &&
                  (32'(start_point) < MAX_POINTS);
  assign seg_waddr = {LW'(seg_len_index), PW'(start_point)};
  assign seg_raddr = {LW'(j - i - 1'b1), PW'(i)};

  osd_ram #(.W(COST_W), .D(2 ** SEG_AW)) u_seg (
    .clk(clk), .we(seg_we), .waddr(seg_waddr), .wdata(cost_value),
    .raddr(seg_raddr), .rdata(seg_rdata)
  );

  assign col_we     = (state == S_WRCOL);
  assign col_waddr  = {CPW'(c), j};
  assign best_raddr = (state == S_SCAN) ? {CPW'(c - 3'd1), i} : {CPW'(c), n};
  assign bp_raddr   = {CPW'(s), pos};

  osd_ram #(.W(COST_W), .D(2 ** TAB_AW)) u_best (
    .clk(clk), .we(col_we), .waddr(col_waddr), .wdata(zmin),
    .raddr(best_raddr), .rdata(best_rdata)
  );

  osd_ram #(.W(CW), .D(2 ** TAB_AW)) u_bp (
    .clk(clk), .we(col_we), .waddr(col_waddr), .wdata(imin),
    .raddr(bp_raddr), .rdata(bp_rdata)
  );

  // row zero sees a virtual previous row: zero at column 0, infinite elsewhere
  always_comb begin
    if (c == '0) prev_cost = (i_d == '0) ? '0 : COST_INF;
    else prev_cost = best_rdata;
    seg_term = eq_d ? '0 : seg_rdata;
    z = sat_add(prev_cost, seg_term);
  end

  // boundary chain
  assign cctl.clear = (state == S_ROWRD);
  assign cctl.push  = (state == S_TOT) || (state == S_BTWAIT);
  assign cctl.pop   = (state == S_EMIT) && out_free;
  assign push_val   = (state == S_TOT) ? BND_W'(n) : BND_W'(bp_rdata);

  for (genvar k = 0; k < MAX_CP; k++) begin : g_chain
    logic [BND_W-1:0] left, right;
    if (k == 0) begin : g_head
      assign left = push_val;
    end else begin : g_body
      assign left = chain[k-1];
    end
    if (k == MAX_CP - 1) begin : g_tail
      assign right = '0;
    end else begin : g_mid
      assign right = chain[k+1];
    end
    osd_cell u_cell (.clk(clk), .ctl(cctl), .left(left), .right(right), .val(chain[k]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      v1          <= 1'b0;
      out_valid   <= 1'b0;
      num_points  <= NP_W'(256);
      max_seg_len <= ML_W'(64);
      num_cp_rows <= NR_W'(8);
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          REG_NUM_POINTS:  num_points  <= cfg_data[NP_W-1:0];
          REG_MAX_SEG_LEN: max_seg_len <= cfg_data[ML_W-1:0];
          REG_NUM_CP_ROWS: num_cp_rows <= cfg_data[NR_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall && state != S_EMIT) out_valid <= 1'b0;

      // candidate compare, in the cycle after the reads; ties keep the earlier i
      v1 <= (state == S_SCAN);
      if (v1 && z < zmin) begin
        zmin <= z;
        imin <= i_d;
      end

      case (state)
        S_IDLE: begin
          if (in_acc && mode == MODE_RUN) begin
            n       <= n_start;
            ml      <= ml_start;
            rows_m1 <= rows_start;
            c       <= '0;
            j       <= '0;
            state   <= S_COLINIT;
          end
        end
        S_COLINIT: begin
          i     <= (j > ml) ? j - ml : '0;
          zmin  <= COST_INF;
          imin  <= j;
          state <= S_SCAN;
        end
        S_SCAN: begin
          i_d  <= i;
          eq_d <= (i == j);
          if (i == j) state <= S_DRAIN;
          else i <= i + 1'b1;
        end
        S_DRAIN: state <= S_WRCOL;
        S_WRCOL: begin
          if (j == n) begin
            j <= '0;
            if (c == rows_m1) begin
              c     <= '0;
              sl    <= '0;
              state <= S_ROWRD;
            end else begin
              c     <= c + 1'b1;
              state <= S_COLINIT;
            end
          end else begin
            j     <= j + 1'b1;
            state <= S_COLINIT;
          end
        end
        S_ROWRD: state <= S_TOT;
        S_TOT: begin
          total <= best_rdata;
          pos   <= n;
          s     <= c;
          state <= (c == '0) ? S_EMIT : S_BTRD;
        end
        S_BTRD: state <= S_BTWAIT;
        S_BTWAIT: begin
          pos   <= bp_rdata;
          s     <= s - 1'b1;
          state <= (s == CNT_W'(1)) ? S_EMIT : S_BTRD;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            change_count <= c;
            slot         <= sl;
            boundary     <= chain[0];
            total_cost   <= total;
            infeasible   <= (total == COST_INF);
            last         <= (c == rows_m1) && (sl == rows_m1);
            if (sl == rows_m1) begin
              sl <= '0;
              if (c == rows_m1) state <= S_IDLE;
              else begin
                c     <= c + 1'b1;
                state <= S_ROWRD;
              end
            end else begin
              sl <= sl + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### hw/rtl/osd_checker.sv
module osd_checker import osd_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [CNT_W-1:0]      change_count,
  input logic [CNT_W-1:0]      slot,
  input logic [BND_W-1:0]      boundary,
  input logic [COST_W-1:0]     total_cost,
  input logic                  infeasible
);
`include "optimal_segmentation_dp_assert.svh"

  // a held beat stays up
  `OSD_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid)
  // infinite flag tracks the saturated cost
  `OSD_ASSERT_IMPLY(a_inf, clk, rst, out_valid, infeasible == (total_cost == COST_INF))
  // the closing boundary of a row is the point count, never zero
  `OSD_ASSERT_IMPLY(a_end, clk, rst, out_valid && slot == change_count, boundary != '0)
  // slots past the closing boundary are unused
  `OSD_ASSERT_IMPLY(a_unused, clk, rst, out_valid && slot > change_count, boundary == '0)
endmodule

bind optimal_segmentation_dp osd_checker u_osd_checker (.*);

### tb/optimal_segmentation_dp_test.sv
module optimal_segmentation_dp_test;
  import osd_pkg::*;

  localparam int TAB_LEN  = 64;
  localparam int TAB_PTS  = 256;
  localparam int ROWS_MAX = 8;
  localparam int STALL_LIMIT = 100000;

  typedef struct packed {
    bit [2:0]  change_count;
    bit [2:0]  slot;
    bit [8:0]  boundary;
    bit [31:0] total_cost;
    bit        infeasible;
    bit        last;
  } seg_result_t;

  class segment_board;
    bit [31:0]   cost_tbl[TAB_LEN][TAB_PTS];
    bit [31:0]   best[ROWS_MAX][TAB_PTS+1];
    int          back[ROWS_MAX][TAB_PTS+1];
    int          num_points = 256;
    int          max_len = 64;
    int          num_rows = 8;
    seg_result_t due_q[$];
    int          errors;
    int          checked;

    function bit [31:0] add_sat(bit [31:0] a, bit [31:0] b);
      bit [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (a == COST_INF || b == COST_INF || s >= {1'b0, COST_INF}) return COST_INF;
      return s[31:0];
    endfunction

    function int clamp(int v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function bit [31:0] span_cost(int i, int j);
      if (i == j) return 0;
      return cost_tbl[j-i-1][i];
    endfunction

    function void set_reg(bit [1:0] idx, bit [8:0] val);
      case (idx)
        REG_NUM_POINTS:  num_points = val;
        REG_MAX_SEG_LEN: max_len = val[6:0];
        REG_NUM_CP_ROWS: num_rows = val[3:0];
        default: ;
      endcase
    endfunction

    // load beats fill the table, a run beat solves every row and queues its boundaries
    function void note_beat(bit m, bit [5:0] len, bit [7:0] st, bit [31:0] cv);
      int n, ml, rows, i0, pos;
      bit [31:0] z, zmin, total;
      int imin;
      int bnd[ROWS_MAX];
      seg_result_t r;
      if (m == MODE_LOAD) begin
        cost_tbl[len][st] = cv;
        return;
      end
      n = clamp(num_points, TAB_PTS);
      ml = clamp(max_len, TAB_LEN);
      rows = clamp(num_rows, ROWS_MAX);
      for (int j = 0; j <= n; j++)
        best[0][j] = (j <= ml) ? span_cost(0, j) : COST_INF;
      for (int c = 1; c < rows; c++) begin
        for (int j = 0; j <= n; j++) begin
          zmin = COST_INF;
          imin = j;
          i0 = (j > ml) ? j - ml : 0;
          for (int i = i0; i <= j; i++) begin
            z = add_sat(best[c-1][i], span_cost(i, j));
            if (z < zmin) begin
              zmin = z;
              imin = i;
            end
          end
          best[c][j] = zmin;
          back[c][j] = imin;
        end
      end
      for (int c = 0; c < rows; c++) begin
        total = best[c][n];
        foreach (bnd[s]) bnd[s] = 0;
        bnd[c] = n;
        pos = n;
        for (int s = c; s > 0; s--) begin
          pos = back[s][pos];
          bnd[s-1] = pos;
        end
        for (int s = 0; s < rows; s++) begin
          r.change_count = 3'(c);
          r.slot = 3'(s);
          r.boundary = 9'(bnd[s]);
          r.total_cost = total;
          r.infeasible = (total == COST_INF);
          r.last = (c == rows - 1 && s == rows - 1);
          due_q.push_back(r);
        end
      end
    endfunction

    function void check_result(seg_result_t got);
      seg_result_t exp_r;
      checked++;
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t: expected no beat, got row %0d slot %0d boundary %0d", $realtime,
                 got.change_count, got.slot, got.boundary);
        return;
      end
      exp_r = due_q.pop_front();
      if (exp_r != got) begin
        errors++;
        $display("%0t: expected c%0d s%0d b%0d cost %h inf %0d last %0d, got c%0d s%0d b%0d cost %h inf %0d last %0d",
                 $realtime, exp_r.change_count, exp_r.slot, exp_r.boundary, exp_r.total_cost,
                 exp_r.infeasible, exp_r.last, got.change_count, got.slot, got.boundary,
                 got.total_cost, got.infeasible, got.last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic mode = MODE_LOAD;
  logic [5:0] seg_len_index = '0;
  logic [7:0] start_point = '0;
  logic [COST_W-1:0] cost_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CNT_W-1:0] change_count;
  logic [CNT_W-1:0] slot;
  logic [BND_W-1:0] boundary;
  logic [COST_W-1:0] total_cost;
  logic infeasible;
  logic last;

  segment_board board = new();
  bit loaded[TAB_LEN][TAB_PTS];
  int send_pct = 0;
  int stall_pct = 0;
  int beats_in = 0;
  int runs_done = 0;
  int quiet_cycles = 0;

  optimal_segmentation_dp i_dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    seg_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.change_count = change_count;
      got.slot = slot;
      got.boundary = boundary;
      got.total_cost = total_cost;
      got.infeasible = infeasible;
      got.last = last;
      board.check_result(got);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  function bit [31:0] pick_cost(bit tie_heavy);
    if (tie_heavy) return $urandom_range(0, 3);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return COST_INF;
      2: return COST_INF - $urandom_range(1, 3);
      3: return {1'b1, 31'($urandom)};
      4, 5, 6: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_beat(bit m, bit [5:0] len, bit [7:0] st, bit [31:0] cv);
    if ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    mode <= m;
    seg_len_index <= len;
    start_point <= st;
    cost_value <= cv;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    board.note_beat(m, len, st, cv);
    if (m == MODE_LOAD) loaded[len][st] = 1'b1;
    beats_in++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.due_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_regs(bit [8:0] np, bit [8:0] ml, bit [8:0] rows);
    cfg_write_en <= 1'b1;
    cfg_index <= REG_NUM_POINTS;
    cfg_data <= np;
    @(negedge clk);
    board.set_reg(REG_NUM_POINTS, np);
    cfg_index <= REG_MAX_SEG_LEN;
    cfg_data <= ml;
    @(negedge clk);
    board.set_reg(REG_MAX_SEG_LEN, ml);
    cfg_index <= REG_NUM_CP_ROWS;
    cfg_data <= rows;
    @(negedge clk);
    board.set_reg(REG_NUM_CP_ROWS, rows);
    cfg_write_en <= 1'b0;
  endtask

  // every entry the run can read gets written first, some are refreshed
  task automatic solve_case(bit [8:0] np, bit [8:0] ml, bit [8:0] rows, int stray,
                            bit tie_heavy, bit hold_off);
    int n, lm;
    drain();
    set_regs(np, ml, rows);
    n = board.clamp(board.num_points, TAB_PTS);
    lm = board.clamp(board.max_len, TAB_LEN);
    if (lm > n) lm = n;
    for (int len = 1; len <= lm; len++)
      for (int st = 0; st + len <= n; st++)
        if (!loaded[len-1][st] || $urandom_range(0, 7) == 0)
          send_beat(MODE_LOAD, 6'(len - 1), 8'(st), pick_cost(tie_heavy));
    repeat (stray) send_beat(MODE_LOAD, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                             pick_cost(1'b0));
    if (hold_off) drain();
    send_beat(MODE_RUN, 6'($urandom), 8'($urandom), $urandom);
    runs_done++;
  endtask

  initial begin
    int phase;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    solve_case(4, 2, 3, 0, 1'b0, 1'b0);
    solve_case(1, 1, 1, 0, 1'b0, 1'b0);
    solve_case(0, 0, 0, 0, 1'b0, 1'b0);
    solve_case(6, 3, 4, 0, 1'b1, 1'b1);
    solve_case(256, 1, 8, 0, 1'b0, 1'b0);
    solve_case(10, 64, 8, 0, 1'b0, 1'b0);
    solve_case(12, 127, 15, 0, 1'b1, 1'b0);
    solve_case(511, 1, 2, 0, 1'b0, 1'b0);

    while (beats_in < 410) begin
      phase = (runs_done / 3) % 4;
      send_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 49 : 29) : 0;
      stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 49 : 29) : 0;
      solve_case(9'($urandom_range(1, 20)), 9'($urandom_range(1, 8)), 9'($urandom_range(1, 8)),
                 $urandom_range(0, 2), ($urandom_range(0, 3) == 0),
                 ($urandom_range(0, 7) == 0));
    end

    drain();
    repeat (20) @(posedge clk);
    $display("%0d input beats, %0d segmentation runs, %0d result beats checked",
             beats_in, runs_done, board.checked);
    $display("runs spanned register extremes and clamping, ties and saturated costs");
    if (board.errors == 0 && board.due_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
